// ----- hw/rtl/gsq_pkg.sv -----
`default_nettype none
package gsq_pkg;

    localparam int LFSR_W         = 31;
    localparam int DATA_W         = 16;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 32;
    localparam int WARMUP         = 1600;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_MODE = CFG_IDX_W'(1);

    localparam logic signed [DATA_W-1:0] SOFT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] SOFT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef logic [LFSR_W-1:0] t_lfsr;
    typedef t_lfsr [LFSR_W-1:0] t_jump_cols;

    // One queue entry between the front and the back.
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic                     chip;
        logic                     last;
    } t_item;

    // x1(n+31) = x1(n+3) xor x1(n)
    function automatic t_lfsr adv_one(input t_lfsr r);
        return {r[3] ^ r[0], r[LFSR_W-1:1]};
    endfunction

    // x2(n+31) = x2(n+3) xor x2(n+2) xor x2(n+1) xor x2(n)
    function automatic t_lfsr adv_two(input t_lfsr r);
        return {r[3] ^ r[2] ^ r[1] ^ r[0], r[LFSR_W-1:1]};
    endfunction

    // State of the first register after the warmup, starting from one.
    // The warmup runs in short inner loops of 32 steps each.
    function automatic t_lfsr warm_one_value();
        t_lfsr v;
        v = t_lfsr'(1);
        for (int h = 0; h < WARMUP; h += 32) begin
            for (int k = h; (k < WARMUP) && (k < h + 32); k++) begin
                v = adv_one(v);
            end
        end
        return v;
    endfunction

    // Column i is where seed bit i lands after the warmup; the second
    // register is linear, so any seed maps by XOR of its columns.
    function automatic t_jump_cols jump_two_cols();
        t_jump_cols cols;
        t_lfsr      v;
        for (int i = 0; i < LFSR_W; i++) begin
            v = t_lfsr'(1) << i;
            for (int h = 0; h < WARMUP; h += 32) begin
                for (int k = h; (k < WARMUP) && (k < h + 32); k++) begin
                    v = adv_two(v);
                end
            end
            cols[i] = v;
        end
        return cols;
    endfunction

    localparam t_lfsr      WARM_ONE = warm_one_value();
    localparam t_jump_cols JUMP_TWO = jump_two_cols();

    function automatic t_lfsr jump_two(input t_lfsr seed);
        t_lfsr acc;
        acc = '0;
        for (int i = 0; i < LFSR_W; i++) begin
            if (seed[i]) begin
                acc = acc ^ JUMP_TWO[i];
            end
        end
        return acc;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/gsq_front.sv -----
`default_nettype none
module gsq_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_seed_we,
    input  wire gsq_pkg::t_lfsr              i_seed,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire logic signed [gsq_pkg::DATA_W-1:0] i_data,
    input  wire                              i_last,
    input  wire                              i_room,
    output logic                             o_push,
    output gsq_pkg::t_item                   o_item
);

    logic           r_restart;
    gsq_pkg::t_lfsr r_lfsr_one;
    gsq_pkg::t_lfsr r_lfsr_two;
    gsq_pkg::t_lfsr r_warm_two;
    gsq_pkg::t_lfsr cur_one;
    gsq_pkg::t_lfsr cur_two;
    logic           chip;

    assign o_ready = i_room;
    assign o_push  = i_valid & i_room;

    // At a sequence start the registers come from the precomputed warm states.
    always_comb begin
        cur_one = r_restart ? gsq_pkg::WARM_ONE : r_lfsr_one;
        cur_two = r_restart ? r_warm_two : r_lfsr_two;
        chip    = cur_one[0] ^ cur_two[0];
    end

    assign o_item = '{data: i_data, chip: chip, last: i_last};

    // The seed is jumped ahead when it is written, so a restart does not stall the stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm_two <= '0;
        end else if (i_seed_we) begin
            r_warm_two <= gsq_pkg::jump_two(i_seed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart <= 1'b1;
        end else if (o_push) begin
            r_restart <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_lfsr_one <= gsq_pkg::adv_one(cur_one);
            r_lfsr_two <= gsq_pkg::adv_two(cur_two);
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/gsq_fifo.sv -----
`default_nettype none
module gsq_fifo #(
    parameter int DEPTH = gsq_pkg::FIFO_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire gsq_pkg::t_item i_item,
    input  wire                 i_pop,
    output gsq_pkg::t_item      o_item,
    output logic                o_empty,
    output logic                o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gsq_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/gsq_back.sv -----
`default_nettype none
module gsq_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_soft_mode,
    input  wire gsq_pkg::t_item i_item,
    input  wire                 i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [gsq_pkg::DATA_W-1:0] o_data,
    output logic                o_chip,
    output logic                o_last
);

    logic                              r_valid;
    logic signed [gsq_pkg::DATA_W-1:0] r_data;
    logic                              r_chip;
    logic                              r_last;
    logic signed [gsq_pkg::DATA_W-1:0] n_data;

    assign o_pop = !i_empty && (!r_valid || i_ready);

    // Soft mode negates on a one chip, the most negative value saturating; hard mode XORs bit 0 with the chip.
    always_comb begin
        if (i_soft_mode) begin
            if (!i_item.chip) begin
                n_data = i_item.data;
            end else if (i_item.data == gsq_pkg::SOFT_MIN) begin
                n_data = gsq_pkg::SOFT_MAX;
            end else begin
                n_data = -i_item.data;
            end
        end else begin
            n_data = {{(gsq_pkg::DATA_W-1){1'b0}}, i_item.data[0] ^ i_item.chip};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
            r_chip <= i_item.chip;
            r_last <= i_item.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_chip  = r_chip;
    assign o_last  = r_last;

endmodule
`default_nettype wire

// ----- hw/rtl/gold_sequence_scrambler_top.sv -----
// Gold sequence scrambler and soft descrambler, LTE style, length 31.
// Input stream: i_s_tdata carries one hard bit (bit 0) or a signed 16-bit
// soft value per beat; i_s_tlast ends a sequence, and the next beat starts
// a new one from the current seed.
// Output stream: o_m_tdata is the scrambled bit or the sign-adjusted soft
// value, o_m_tuser the chip applied, o_m_tlast the echoed last flag.
// Configuration: index 0 writes the 31-bit seed, index 1 selects soft mode.
// Write only while no beats are in flight; other indexes are ignored.
// Throughput is one beat per cycle while the output side is ready, including
// sequence restarts: the warmup jump of the seeded register is computed when
// the seed is written, and the other register starts from a fixed warm state.
// An accepted input beat is written into the queue and then popped into the
// output register, from which the output side takes it. A small queue
// decouples the generator from the output register; if the receiver stalls,
// the queue and the output register fill and i_s_tready drops, and no beat is
// lost. Reset empties the queue, clears the configuration and arms a sequence
// restart for the next input beat.
`default_nettype none
module gold_sequence_scrambler_top #(
    parameter int FIFO_DEPTH = gsq_pkg::FIFO_DEPTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Configuration write channel.
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [gsq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [gsq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream.
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire [gsq_pkg::DATA_W-1:0]        i_s_tdata,   // [15:0] data_in
    input  wire                              i_s_tlast,   // last
    // Output stream.
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [gsq_pkg::DATA_W-1:0]       o_m_tdata,   // [15:0] data_out
    output logic                             o_m_tuser,   // [0] chip_bit
    output logic                             o_m_tlast    // last_out
);

    logic           r_soft_mode;
    logic           w_seed_we;
    logic           w_push;
    logic           w_pop;
    logic           w_fifo_empty;
    logic           w_fifo_full;
    gsq_pkg::t_item w_front_item;
    gsq_pkg::t_item w_back_item;

    assign o_cfg_ready = 1'b1;
    assign w_seed_we   = i_cfg_valid && (i_cfg_index == gsq_pkg::CFG_INIT_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft_mode <= 1'b0;
        end else if (i_cfg_valid && (i_cfg_index == gsq_pkg::CFG_SOFT_MODE)) begin
            r_soft_mode <= i_cfg_data[0];
        end
    end

    gsq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seed_we (w_seed_we),
        .i_seed  (i_cfg_data[gsq_pkg::LFSR_W-1:0]),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_room  (!w_fifo_full),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    gsq_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_back_item),
        .o_empty (w_fifo_empty),
        .o_full  (w_fifo_full)
    );

    gsq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_soft_mode (r_soft_mode),
        .i_item      (w_back_item),
        .i_empty     (w_fifo_empty),
        .o_pop       (w_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata),
        .o_chip      (o_m_tuser),
        .o_last      (o_m_tlast)
    );

    a_pop_not_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_empty)
        else $error("queue popped while empty");

    a_push_has_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo_full)
        else $error("queue pushed while full");

    a_pop_fills_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_m_tvalid)
        else $error("popped beat did not reach the output register");

endmodule
`default_nettype wire
